// ===== sv/scbp_pkg.sv =====
// Shared constants and types for the size-class buffer pool.
// No dependencies; compiled first.
package scbp_pkg;

	// Field widths
	localparam int unsigned SIZE_W   = 16;
	localparam int unsigned INDEX_W  = 10;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned GSIZE_W  = 15;
	localparam int unsigned CLASS_W  = 2;
	localparam int unsigned COUNT_W  = 11;
	localparam int unsigned NUM_CLASSES = 4;

	// Default buffer counts per class
	localparam int unsigned COUNT_2K_DEF  = 1024;
	localparam int unsigned COUNT_4K_DEF  = 128;
	localparam int unsigned COUNT_8K_DEF  = 64;
	localparam int unsigned COUNT_16K_DEF = 32;

	// Class sizes in bytes, smallest first
	localparam logic [GSIZE_W-1:0] CLASS_BYTES [NUM_CLASSES] = '{
		15'(2 * 1024), 15'(4 * 1024), 15'(8 * 1024), 15'(16 * 1024)
	};

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_INDEX = 3'd4
	} status_t;

endpackage

// ===== sv/scbp_req_if.sv =====
// Request channel of the size-class buffer pool: valid/ready plus request fields.
// Depends on scbp_pkg for field widths.
interface scbp_req_if;
	logic                               valid;
	logic                               ready;
	logic                               opcode;
	logic [scbp_pkg::SIZE_W-1:0]        request_size;
	logic [scbp_pkg::INDEX_W-1:0]       release_index;

	modport source (output valid, opcode, request_size, release_index, input ready);
	modport sink   (input valid, opcode, request_size, release_index, output ready);
endinterface

// ===== sv/scbp_rsp_if.sv =====
// Result channel of the size-class buffer pool: valid/ready plus result fields.
// Depends on scbp_pkg for field widths.
interface scbp_rsp_if;
	logic                               valid;
	logic                               ready;
	logic [scbp_pkg::STATUS_W-1:0]      status;
	logic [scbp_pkg::GSIZE_W-1:0]       granted_size;
	logic [scbp_pkg::CLASS_W-1:0]       size_class;
	logic [scbp_pkg::INDEX_W-1:0]       granted_index;
	logic [scbp_pkg::COUNT_W-1:0]       in_use_count;

	modport source (output valid, status, granted_size, size_class, granted_index,
		in_use_count, input ready);
	modport sink   (input valid, status, granted_size, size_class, granted_index,
		in_use_count, output ready);
endinterface

// ===== sv/scbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scbp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic             clk,
	input  logic             we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/size_class_buffer_pool.sv =====
// Size-class buffer pool: four LIFO free lists (2/4/8/16 KiB) with in-use counters.
// Depends on scbp_pkg, scbp_req_if, scbp_rsp_if and scbp_ram.
//
// Accepts one allocate or free request per cycle and returns one result per
// request, in order, after the input register and then the result register,
// which takes the free-list RAM read along with it. Stack pointers and
// counters update in the input stage, so back-to-back requests to the same
// class see each other's effect. No clearing pass is needed after reset: each
// class keeps a low-water mark of its stack depth, and a pop at that mark
// returns the position itself (the reset contents) instead of the RAM data.
// Backpressure on the result side stalls both stages.
module size_class_buffer_pool #(
	parameter int unsigned COUNT_2K  = scbp_pkg::COUNT_2K_DEF,
	parameter int unsigned COUNT_4K  = scbp_pkg::COUNT_4K_DEF,
	parameter int unsigned COUNT_8K  = scbp_pkg::COUNT_8K_DEF,
	parameter int unsigned COUNT_16K = scbp_pkg::COUNT_16K_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	scbp_req_if.sink    req,
	scbp_rsp_if.source  rsp
);
	import scbp_pkg::*;

	localparam int unsigned CNT_INT [NUM_CLASSES] = '{COUNT_2K, COUNT_4K, COUNT_8K, COUNT_16K};
	localparam logic [COUNT_W-1:0] CNT [NUM_CLASSES] = '{
		COUNT_W'(COUNT_2K), COUNT_W'(COUNT_4K), COUNT_W'(COUNT_8K), COUNT_W'(COUNT_16K)
	};

	// Handshake
	logic advance, in_ready, fire1;

	// Input stage
	logic                 valid_s1;
	logic                 op_s1;
	logic [SIZE_W-1:0]    size_s1;
	logic [INDEX_W-1:0]   idx_s1;

	// Per-class state
	logic [COUNT_W-1:0] depth_q [NUM_CLASSES];
	logic [COUNT_W-1:0] low_q   [NUM_CLASSES];
	logic [COUNT_W-1:0] used_q  [NUM_CLASSES];

	// Input-stage decode
	logic [CLASS_W-1:0]  cls;
	logic                too_large;
	logic [COUNT_W-1:0]  depth_c, used_c, cnt_c, pos_c, used_new;
	logic                pop_ok, push_ok, at_low;
	status_t             status_c;

	// Result stage
	logic                 valid_s2;
	status_t              status_s2;
	logic [GSIZE_W-1:0]   gsize_s2;
	logic [CLASS_W-1:0]   class_s2;
	logic                 grant_s2;
	logic                 from_ram_s2;
	logic [INDEX_W-1:0]   pos_s2;
	logic [COUNT_W-1:0]   used_s2;

	logic [INDEX_W-1:0] rdata_ext [NUM_CLASSES];

	assign advance  = !valid_s2 || rsp.ready;
	assign in_ready = !valid_s1 || advance;
	assign fire1    = valid_s1 && advance;
	assign req.ready = in_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && req.valid) begin
			op_s1   <= req.opcode;
			size_s1 <= req.request_size;
			idx_s1  <= req.release_index;
		end
	end

	// Class select and stack decision
	always_comb begin
		too_large = 1'b0;
		if (size_s1 <= {1'b0, CLASS_BYTES[0]}) begin
			cls = 2'd0;
		end else if (size_s1 <= {1'b0, CLASS_BYTES[1]}) begin
			cls = 2'd1;
		end else if (size_s1 <= {1'b0, CLASS_BYTES[2]}) begin
			cls = 2'd2;
		end else begin
			cls = 2'd3;
			too_large = (size_s1 > {1'b0, CLASS_BYTES[3]});
		end

		depth_c = depth_q[cls];
		used_c  = used_q[cls];
		cnt_c   = CNT[cls];
		pos_c   = depth_c - COUNT_W'(1);
		at_low  = (depth_c == low_q[cls]);
		pop_ok  = 1'b0;
		push_ok = 1'b0;
		used_new = used_c;

		if (too_large) begin
			status_c = ST_TOO_LARGE;
		end else if (op_s1 == OP_ALLOC) begin
			if (depth_c == '0) begin
				status_c = ST_EMPTY;
			end else begin
				status_c = ST_OK;
				pop_ok   = 1'b1;
				if (used_c < cnt_c) begin
					used_new = used_c + COUNT_W'(1);
				end
			end
		end else begin
			if ({1'b0, idx_s1} >= cnt_c) begin
				status_c = ST_BAD_INDEX;
			end else if (depth_c >= cnt_c) begin
				status_c = ST_FULL;
			end else begin
				status_c = ST_OK;
				push_ok  = 1'b1;
				if (used_c != '0) begin
					used_new = used_c - COUNT_W'(1);
				end
			end
		end
	end

	// Stack pointers, low-water marks and in-use counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_CLASSES; k++) begin
				depth_q[k] <= CNT[k];
				low_q[k]   <= CNT[k];
				used_q[k]  <= '0;
			end
		end else if (fire1) begin
			used_q[cls] <= used_new;
			if (pop_ok) begin
				depth_q[cls] <= pos_c;
				if (at_low) begin
					low_q[cls] <= pos_c;
				end
			end else if (push_ok) begin
				depth_q[cls] <= depth_c + COUNT_W'(1);
			end
		end
	end

	// One free-list RAM per class, index width sized to the class count
	for (genvar k = 0; k < NUM_CLASSES; k++) begin : g_class
		localparam int unsigned AW = (CNT_INT[k] > 1) ? $clog2(CNT_INT[k]) : 1;
		logic          we_k, re_k;
		logic [AW-1:0] rdata_k;

		assign we_k = fire1 && push_ok && (cls == CLASS_W'(k));
		assign re_k = fire1 && pop_ok && !at_low && (cls == CLASS_W'(k));

		scbp_ram #(
			.WIDTH (AW),
			.DEPTH (CNT_INT[k])
		) u_ram (
			.clk   (clk),
			.we    (we_k),
			.waddr (depth_c[AW-1:0]),
			.wdata (idx_s1[AW-1:0]),
			.re    (re_k),
			.raddr (pos_c[AW-1:0]),
			.rdata (rdata_k)
		);

		assign rdata_ext[k] = INDEX_W'(rdata_k);
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			status_s2   <= status_c;
			gsize_s2    <= pop_ok ? CLASS_BYTES[cls] : '0;
			class_s2    <= too_large ? '0 : cls;
			grant_s2    <= pop_ok;
			from_ram_s2 <= !at_low;
			pos_s2      <= pos_c[INDEX_W-1:0];
			used_s2     <= too_large ? '0 : used_new;
		end
	end

	// Result beat
	assign rsp.valid         = valid_s2;
	assign rsp.status        = status_s2;
	assign rsp.granted_size  = gsize_s2;
	assign rsp.size_class    = class_s2;
	assign rsp.granted_index = !grant_s2 ? '0 :
		(from_ram_s2 ? rdata_ext[class_s2] : pos_s2);
	assign rsp.in_use_count  = used_s2;

endmodule

// ===== tb/sv/tb_size_class_buffer_pool.sv =====
`timescale 1ns / 1ps
// Testbench for size_class_buffer_pool: random and directed allocate/free traffic
// checked against a behavioral free-list model. Needs scbp_pkg and both channel interfaces.
module tb_size_class_buffer_pool;
	import scbp_pkg::*;

	localparam int unsigned POOL_COUNT [NUM_CLASSES] = '{
		COUNT_2K_DEF, COUNT_4K_DEF, COUNT_8K_DEF, COUNT_16K_DEF
	};
	localparam int N_ITEMS     = 1150;
	localparam int PHASE1_AT   = 380;
	localparam int PHASE2_AT   = 760;
	localparam int HOLD_AT     = 850;
	localparam int HOLD_CYCLES = 64;
	localparam int DRAIN_EVERY = 350;

	typedef struct {
		bit                  drain;
		opcode_t             op;
		logic [SIZE_W-1:0]   size;
		logic [INDEX_W-1:0]  idx;
	} pool_request_t;

	typedef struct packed {
		status_t             status;
		logic [GSIZE_W-1:0]  gsize;
		logic [CLASS_W-1:0]  cls;
		logic [INDEX_W-1:0]  gidx;
		logic [COUNT_W-1:0]  used;
	} pool_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	scbp_req_if req_ch();
	scbp_rsp_if rsp_ch();

	size_class_buffer_pool u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model state: one LIFO per class plus depth and in-use counters
	logic [INDEX_W-1:0] free_list [NUM_CLASSES][1024];
	int unsigned        free_top [NUM_CLASSES];
	int unsigned        in_use [NUM_CLASSES];

	pool_request_t pending_requests [$];
	pool_result_t  expected_results [$];
	int            n_accepted = 0;
	int            n_errors = 0;

	function automatic void reset_pool();
		for (int c = 0; c < NUM_CLASSES; c++) begin
			for (int i = 0; i < POOL_COUNT[c]; i++)
				free_list[c][i] = INDEX_W'(i);
			free_top[c] = POOL_COUNT[c];
			in_use[c] = 0;
		end
	endfunction

	// Apply one request to the model and return the result it should produce
	function automatic pool_result_t pool_step(opcode_t op, logic [SIZE_W-1:0] size,
		logic [INDEX_W-1:0] idx);
		pool_result_t r;
		int           c;
		int unsigned  cnt;
		r = '0;
		r.status = ST_OK;
		if (size > CLASS_BYTES[NUM_CLASSES-1]) begin
			r.status = ST_TOO_LARGE;
			return r;
		end
		c = NUM_CLASSES - 1;
		for (int k = NUM_CLASSES - 1; k >= 0; k--)
			if (size <= CLASS_BYTES[k])
				c = k;
		cnt = POOL_COUNT[c];
		r.cls = CLASS_W'(c);
		if (op == OP_ALLOC) begin
			if (free_top[c] == 0) begin
				r.status = ST_EMPTY;
			end else begin
				free_top[c]--;
				r.gidx = free_list[c][free_top[c]];
				r.gsize = CLASS_BYTES[c];
				if (in_use[c] < cnt)
					in_use[c]++;
			end
		end else if (idx >= cnt) begin
			r.status = ST_BAD_INDEX;
		end else if (free_top[c] >= cnt) begin
			r.status = ST_FULL;
		end else begin
			free_list[c][free_top[c]] = idx;
			free_top[c]++;
			if (in_use[c] > 0)
				in_use[c]--;
		end
		r.used = COUNT_W'(in_use[c]);
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		n_errors++;
	endtask

	task automatic queue_request(opcode_t op, int unsigned size, int unsigned idx);
		pool_request_t r;
		r.drain = 1'b0;
		r.op = op;
		r.size = SIZE_W'(size);
		r.idx = INDEX_W'(idx);
		pending_requests.push_back(r);
	endtask

	task automatic queue_drain();
		pool_request_t r;
		r.drain = 1'b1;
		r.op = OP_ALLOC;
		r.size = '0;
		r.idx = '0;
		pending_requests.push_back(r);
	endtask

	function automatic int unsigned size_in_class(int c);
		int unsigned lo;
		lo = (c == 0) ? 0 : CLASS_BYTES[c-1] + 1;
		return $urandom_range(CLASS_BYTES[c], lo);
	endfunction

	// Traffic is spread over all classes; the largest class gets the most of it
	function automatic int pick_class();
		int unsigned r;
		r = $urandom_range(99, 0);
		if (r < 20)
			return 0;
		else if (r < 45)
			return 1;
		else if (r < 70)
			return 2;
		return 3;
	endfunction

	function automatic int sender_idle_pct();
		if (n_accepted < PHASE1_AT)
			return 29;
		else if (n_accepted < PHASE2_AT)
			return 88;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (n_accepted < PHASE1_AT)
			return 88;
		else if (n_accepted < PHASE2_AT)
			return 29;
		return 0;
	endfunction

	// Request driver: one beat per handshake, fields held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.opcode <= OP_ALLOC;
			req_ch.request_size <= '0;
			req_ch.release_index <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				expected_results.push_back(pool_step(opcode_t'(req_ch.opcode),
					req_ch.request_size, req_ch.release_index));
				pending_requests.delete(0);
				n_accepted++;
			end
			if (!(req_ch.valid && !req_ch.ready)) begin
				// drain marker: hold off until every outstanding result is back
				while (pending_requests.size() > 0 && pending_requests[0].drain &&
					expected_results.size() == 0)
					pending_requests.delete(0);
				if (pending_requests.size() > 0 && !pending_requests[0].drain &&
					$urandom_range(99, 0) >= sender_idle_pct()) begin
					req_ch.valid <= 1'b1;
					req_ch.opcode <= pending_requests[0].op;
					req_ch.request_size <= pending_requests[0].size;
					req_ch.release_index <= pending_requests[0].idx;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_result();
		pool_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("status of a beat with nothing outstanding", rsp_ch.status, 0);
		end else begin
			want = expected_results.pop_front();
			if (rsp_ch.status !== want.status)
				report_mismatch("status", rsp_ch.status, want.status);
			if (rsp_ch.granted_size !== want.gsize)
				report_mismatch("granted_size", rsp_ch.granted_size, want.gsize);
			if (rsp_ch.size_class !== want.cls)
				report_mismatch("size_class", rsp_ch.size_class, want.cls);
			if (rsp_ch.granted_index !== want.gidx)
				report_mismatch("granted_index", rsp_ch.granted_index, want.gidx);
			if (rsp_ch.in_use_count !== want.used)
				report_mismatch("in_use_count", rsp_ch.in_use_count, want.used);
		end
	endtask

	// Result monitor with random stalls and one long hold-off
	int hold_left = 0;
	bit hold_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready)
				check_result();
			if (!hold_done && n_accepted >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99, 0) >= receiver_idle_pct());
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int n_gen;
		int next_drain;
		int c;
		int len;
		int unsigned r;
		reset_pool();

		// Class boundaries, oversize on both opcodes, bad index ahead of full
		queue_request(OP_ALLOC, 0, 0);
		queue_request(OP_ALLOC, 2048, 1023);
		queue_request(OP_ALLOC, 2049, 0);
		queue_request(OP_ALLOC, 4096, 0);
		queue_request(OP_ALLOC, 4097, 0);
		queue_request(OP_ALLOC, 8192, 0);
		queue_request(OP_ALLOC, 8193, 0);
		queue_request(OP_ALLOC, 16384, 0);
		queue_request(OP_ALLOC, 16385, 0);
		queue_request(OP_ALLOC, 65535, 1023);
		queue_request(OP_FREE, 65535, 1023);
		queue_request(OP_FREE, 16385, 3);
		queue_request(OP_FREE, 0, 1023);
		queue_request(OP_FREE, 3000, 128);
		queue_request(OP_FREE, 16384, 1023);
		queue_request(OP_FREE, 5000, 0);
		queue_request(OP_FREE, 8192, 63);
		queue_request(OP_FREE, 6000, 5);
		queue_request(OP_FREE, 7000, 64);
		queue_request(OP_FREE, 2048, 0);
		queue_request(OP_FREE, 1, 0);
		queue_request(OP_ALLOC, 1, 0);
		queue_drain();

		// Random part: bursts of allocations and frees per class, some noise
		n_gen = 22;
		next_drain = n_gen + DRAIN_EVERY;
		while (n_gen < N_ITEMS) begin
			r = $urandom_range(99, 0);
			c = pick_class();
			if (r < 50) begin
				len = $urandom_range(48, 1);
				for (int i = 0; i < len; i++)
					queue_request(OP_ALLOC, size_in_class(c), $urandom_range(1023, 0));
				n_gen += len;
			end else if (r < 90) begin
				len = $urandom_range(40, 1);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(9, 0) == 0 || POOL_COUNT[c] >= 1024)
						queue_request(OP_FREE, size_in_class(c), $urandom_range(1023, 0));
					else
						queue_request(OP_FREE, size_in_class(c),
							$urandom_range(POOL_COUNT[c] - 1, 0));
				end
				n_gen += len;
			end else begin
				queue_request(opcode_t'($urandom_range(1, 0)), $urandom_range(65535, 0),
					$urandom_range(1023, 0));
				n_gen++;
			end
			if (n_gen >= next_drain) begin
				queue_drain();
				next_drain += DRAIN_EVERY;
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_errors == 0 && expected_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog
	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
